### rtl/interval_schedule_tracker_defines.svh
// Assertion macros for the interval schedule tracker.
// Each use expands to one labeled concurrent assertion clocked on clk and
// disabled while rst_n is low; synthesis builds see empty bodies.
`ifndef INTERVAL_SCHEDULE_TRACKER_DEFINES_SVH
`define INTERVAL_SCHEDULE_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define IST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define IST_ASSERT(lbl, prop, msg)
`define IST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/ist_pkg.sv
`timescale 1ns / 1ps

package ist_pkg;

  localparam int MAX_ENTRIES_DEF = 32;

  // request kinds
  typedef enum logic [1:0] {
    KIND_SET_COUNT   = 2'd0,
    KIND_WRITE_ENTRY = 2'd1,
    KIND_TICK        = 2'd2,
    KIND_FORGET      = 2'd3
  } req_kind_t;

  // day status codes
  localparam logic [2:0] DAY_ACTIVE   = 3'd0;
  localparam logic [2:0] DAY_WAITING  = 3'd1;
  localparam logic [2:0] DAY_BREAK    = 3'd2;
  localparam logic [2:0] DAY_FINISHED = 3'd3;
  localparam logic [2:0] DAY_EMPTY    = 3'd4;
  localparam logic [2:0] DAY_NOLIST   = 3'd5;

  // countdown split
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;
  // ceil(2^35 / 225): exact quotient for any 27-bit dividend
  localparam logic [27:0] HOUR_RECIP    = 28'd152709949;
  // ceil(2^14 / 15): exact quotient for any 10-bit dividend
  localparam logic [10:0] MIN_RECIP     = 11'd1093;

  localparam logic [30:0] CD_MAX = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SPLIT,
    ST_EMIT
  } state_t;

  // hit flags reported by the table scan
  typedef struct packed {
    logic act_found;
    logic up_found;
    logic nxt_found;
  } scan_flags_t;

endpackage

### rtl/ist_if.sv
`timescale 1ns / 1ps

// input request channel
interface ist_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] count_value;
  logic signed [31:0] entry_index;
  logic signed [31:0] start_time;
  logic signed [31:0] end_time;
  logic signed [31:0] now_time;

  modport source (output valid, kind, count_value, entry_index, start_time, end_time,
                  now_time, input ready);
  modport sink (input valid, kind, count_value, entry_index, start_time, end_time,
                now_time, output ready);
endinterface

// result channel
interface ist_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         day_kind;
  logic [4:0]         item_index;
  logic [5:0]         ended_count;
  logic [30:0]        countdown;
  logic [19:0]        count_hours;
  logic [5:0]         count_minutes;
  logic [5:0]         count_seconds;
  logic               has_next;
  logic signed [31:0] next_start;
  logic               pulse;

  modport source (output valid, day_kind, item_index, ended_count, countdown, count_hours,
                  count_minutes, count_seconds, has_next, next_start, pulse, input ready);
  modport sink (input valid, day_kind, item_index, ended_count, countdown, count_hours,
                count_minutes, count_seconds, has_next, next_start, pulse, output ready);
endinterface

### rtl/ist_scan.sv
`timescale 1ns / 1ps

// Interval table memories plus a one-entry-per-cycle scan over the live slots.
module ist_scan #(
  parameter int MAX_ENTRIES = ist_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] wr_addr,
  input  logic signed [31:0]  wr_start,
  input  logic signed [31:0]  wr_end,
  input  logic                scan_start,
  input  logic [$clog2(MAX_ENTRIES + 1)-1:0] scan_len,
  input  logic signed [31:0]  now,
  output logic                done,
  output logic [$clog2(MAX_ENTRIES + 1)-1:0] ended,
  output ist_pkg::scan_flags_t flags,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] act_idx,
  output logic signed [31:0]  act_end,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] up_idx,
  output logic signed [31:0]  up_start,
  output logic signed [31:0]  nxt_start
);
  import ist_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic signed [31:0] start_mem [MAX_ENTRIES];
  logic signed [31:0] end_mem   [MAX_ENTRIES];

  logic [CW-1:0]      len_r;
  logic [CW-1:0]      rd_addr_r;
  logic               rd_busy_r;
  logic               eval_v_r;
  logic               eval_last_r;
  logic [IW-1:0]      eval_idx_r;
  logic signed [31:0] q_start_r;
  logic signed [31:0] q_end_r;
  logic               want_next_r;
  logic               done_r;
  logic [CW-1:0]      ended_r;
  scan_flags_t        flags_r;
  logic [IW-1:0]      act_idx_r;
  logic [IW-1:0]      up_idx_r;
  logic signed [31:0] act_end_r;
  logic signed [31:0] up_start_r;
  logic signed [31:0] nxt_start_r;

  logic ge_end;
  logic act_hit;
  logic up_hit;

  // table writes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_addr] <= wr_start;
      end_mem[wr_addr]   <= wr_end;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_busy_r) begin
      q_start_r <= start_mem[rd_addr_r[IW-1:0]];
      q_end_r   <= end_mem[rd_addr_r[IW-1:0]];
    end
  end

  // address sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_busy_r   <= 1'b0;
      rd_addr_r   <= '0;
      len_r       <= '0;
      eval_v_r    <= 1'b0;
      eval_last_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      eval_v_r <= rd_busy_r;
      done_r   <= (eval_v_r && eval_last_r) || (scan_start && (scan_len == '0));
      if (scan_start) begin
        len_r     <= scan_len;
        rd_addr_r <= '0;
        rd_busy_r <= (scan_len != '0);
      end else if (rd_busy_r) begin
        rd_addr_r <= rd_addr_r + CW'(1);
        if (rd_addr_r + CW'(1) == len_r) begin
          rd_busy_r <= 1'b0;
        end
      end
      eval_last_r <= rd_busy_r && (rd_addr_r + CW'(1) == len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_busy_r) begin
      eval_idx_r <= rd_addr_r[IW-1:0];
    end
  end

  assign ge_end  = (now >= q_end_r);
  assign act_hit = (now >= q_start_r) && !ge_end;
  assign up_hit  = (now < q_start_r);

  // evaluate and accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ended_r     <= '0;
      flags_r     <= '0;
      want_next_r <= 1'b0;
    end else if (scan_start) begin
      ended_r     <= '0;
      flags_r     <= '0;
      want_next_r <= 1'b0;
    end else if (eval_v_r) begin
      ended_r     <= ended_r + CW'(ge_end);
      want_next_r <= act_hit && !flags_r.act_found;
      if (act_hit && !flags_r.act_found) begin
        flags_r.act_found <= 1'b1;
      end
      if (up_hit && !flags_r.up_found) begin
        flags_r.up_found <= 1'b1;
      end
      if (want_next_r) begin
        flags_r.nxt_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval_v_r) begin
      if (act_hit && !flags_r.act_found) begin
        act_idx_r <= eval_idx_r;
        act_end_r <= q_end_r;
      end
      if (up_hit && !flags_r.up_found) begin
        up_idx_r   <= eval_idx_r;
        up_start_r <= q_start_r;
      end
      if (want_next_r) begin
        nxt_start_r <= q_start_r;
      end
    end
  end

  assign done      = done_r;
  assign ended     = ended_r;
  assign flags     = flags_r;
  assign act_idx   = act_idx_r;
  assign act_end   = act_end_r;
  assign up_idx    = up_idx_r;
  assign up_start  = up_start_r;
  assign nxt_start = nxt_start_r;

endmodule

### rtl/ist_div.sv
`timescale 1ns / 1ps

// Countdown split into hours, minutes and seconds by reciprocal
// multiplication, one step per cycle; done is registered from the last step.
module ist_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] dividend,
  output logic        busy,
  output logic        done,
  output logic [19:0] hours,
  output logic [5:0]  mins,
  output logic [5:0]  secs
);
  import ist_pkg::*;

  logic [30:0] cd_r;
  logic [19:0] hrs_r;
  logic [11:0] rem_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [3:0]  step_r;
  logic        done_r;

  logic [54:0] prod_h;
  logic [30:0] hrs_secs;
  logic [30:0] rem_full;
  logic [20:0] prod_m;
  logic [11:0] min_secs;
  logic [11:0] sec_full;

  // cd / 3600 equals (cd >> 4) / 225; the reciprocal is scaled by 2^35
  assign prod_h   = 55'(cd_r[30:4]) * 55'(HOUR_RECIP);
  assign hrs_secs = 31'(hrs_r) * 31'(SECS_PER_HOUR);
  assign rem_full = cd_r - hrs_secs;
  // rem / 60 equals (rem >> 2) / 15; the reciprocal is scaled by 2^14
  assign prod_m   = 21'(rem_r[11:2]) * 21'(MIN_RECIP);
  assign min_secs = 12'(min_r) * SECS_PER_MIN;
  assign sec_full = rem_r - min_secs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= start ? 4'b0001 : {step_r[2:0], 1'b0};
      done_r <= step_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cd_r <= dividend;
    end
    if (step_r[0]) begin
      hrs_r <= prod_h[54:35];
    end
    if (step_r[1]) begin
      rem_r <= rem_full[11:0];
    end
    if (step_r[2]) begin
      min_r <= prod_m[19:14];
    end
    if (step_r[3]) begin
      sec_r <= sec_full[5:0];
    end
  end

  assign busy  = |step_r;
  assign done  = done_r;
  assign hours = hrs_r;
  assign mins  = min_r;
  assign secs  = sec_r;

endmodule

### rtl/interval_schedule_tracker.sv
// Interval schedule tracker.
// Requests arrive on in_ch (valid/ready); kind selects set count, write entry,
// tick or forget. Only a tick returns a result on out_ch (valid/ready).
// Set count, forget and a non-committing entry write finish in the accept
// cycle. An entry write that completes the announced list, and every tick,
// scan the live table: one entry per cycle from a memory with a registered
// read port. The scan holds in_ch.ready low until it is done, also for an
// empty or missing list. A tick then splits the countdown by reciprocal
// multiplication and moves to the emit step, which fills the output
// register; in_ch.ready rises again as the result shows on out_ch.
// The result sits in an output register: further requests are
// still taken while it waits for out_ch.ready, and a finished tick waits in
// the emit step until the register frees up. Results never drop or repeat.
// Reset clears the list state and the transition trackers, no list is
// present and the first check after reset never pulses. Table contents are
// not cleared; only slots of the announced list are ever read.
`timescale 1ns / 1ps
`include "interval_schedule_tracker_defines.svh"

module interval_schedule_tracker #(
  parameter int MAX_ENTRIES = ist_pkg::MAX_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ist_in_if.sink    in_ch,
  ist_out_if.source out_ch
);
  import ist_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  // control state
  state_t             state_r, state_nxt;
  logic [CW-1:0]      live_cnt_r, live_cnt_nxt;
  logic [CW-1:0]      pend_cnt_r, pend_cnt_nxt;
  logic               loading_r, loading_nxt;
  logic               have_list_r, have_list_nxt;
  logic               tick_r, tick_nxt;
  // transition trackers: valid bit stands for prev_ended >= 0
  logic               prev_valid_r, prev_valid_nxt;
  logic [CW-1:0]      prev_ended_r, prev_ended_nxt;
  logic               prev_act_valid_r, prev_act_valid_nxt;
  logic [IW-1:0]      prev_act_idx_r, prev_act_idx_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload holding registers
  logic signed [31:0] now_r;
  logic [2:0]         day_r;
  logic [IW-1:0]      idx_r;
  logic [CW-1:0]      ended_r;
  logic [30:0]        cd_r;
  logic               hasn_r;
  logic signed [31:0] nstart_r;
  logic               pulse_r;
  logic [19:0]        hours_r;
  logic [5:0]         mins_r;
  logic [5:0]         secs_r;

  // output register
  logic [2:0]         o_day_r;
  logic [4:0]         o_idx_r;
  logic [5:0]         o_ended_r;
  logic [30:0]        o_cd_r;
  logic [19:0]        o_hours_r;
  logic [5:0]         o_mins_r;
  logic [5:0]         o_secs_r;
  logic               o_hasn_r;
  logic signed [31:0] o_nstart_r;
  logic               o_pulse_r;

  // request decode
  logic               accept;
  req_kind_t          kind;
  logic [CW-1:0]      cnt_clamped;
  logic               entry_ok;
  logic               entry_last;
  logic               wr_en;
  logic               scan_start;
  logic [CW-1:0]      scan_len;

  // scan results
  logic               scan_done;
  logic [CW-1:0]      sc_ended;
  scan_flags_t        sc_flags;
  logic [IW-1:0]      sc_act_idx;
  logic signed [31:0] sc_act_end;
  logic [IW-1:0]      sc_up_idx;
  logic signed [31:0] sc_up_start;
  logic signed [31:0] sc_nxt_start;

  // tick evaluation
  logic [2:0]         day_calc;
  logic [IW-1:0]      idx_calc;
  logic signed [31:0] target;
  logic               use_target;
  logic signed [32:0] diff;
  logic [30:0]        cd_calc;
  logic               pulse_calc;
  logic               load_tick;

  // countdown split
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [19:0]        div_hours;
  logic [5:0]         div_mins;
  logic [5:0]         div_secs;

  logic               emit;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign kind        = req_kind_t'(in_ch.kind);

  // clamp announced count to 0..MAX_ENTRIES
  always_comb begin
    if (in_ch.count_value[31]) begin
      cnt_clamped = '0;
    end else if (in_ch.count_value[30:0] > 31'(MAX_ENTRIES)) begin
      cnt_clamped = CW'(MAX_ENTRIES);
    end else begin
      cnt_clamped = in_ch.count_value[CW-1:0];
    end
  end

  // entry slot must fall inside the pending list
  assign entry_ok   = loading_r && !in_ch.entry_index[31] &&
                      (in_ch.entry_index[30:0] < 31'(pend_cnt_r));
  assign entry_last = (in_ch.entry_index[30:0] == 31'(pend_cnt_r) - 31'd1);
  assign wr_en      = accept && (kind == KIND_WRITE_ENTRY) && entry_ok;
  assign scan_start = accept && ((kind == KIND_TICK) || (wr_en && entry_last));
  assign scan_len   = (kind == KIND_TICK) ? live_cnt_r : pend_cnt_r;

  // the scan reads now_r only in its evaluate step, once now_r is loaded
  ist_scan #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (in_ch.entry_index[IW-1:0]),
    .wr_start  (in_ch.start_time),
    .wr_end    (in_ch.end_time),
    .scan_start(scan_start),
    .scan_len  (scan_len),
    .now       (now_r),
    .done      (scan_done),
    .ended     (sc_ended),
    .flags     (sc_flags),
    .act_idx   (sc_act_idx),
    .act_end   (sc_act_end),
    .up_idx    (sc_up_idx),
    .up_start  (sc_up_start),
    .nxt_start (sc_nxt_start)
  );

  // classify the scan result
  always_comb begin
    day_calc   = DAY_FINISHED;
    idx_calc   = '0;
    target     = sc_act_end;
    use_target = 1'b0;
    if (live_cnt_r == '0) begin
      day_calc = DAY_EMPTY;
    end else if (sc_flags.act_found) begin
      day_calc   = DAY_ACTIVE;
      idx_calc   = sc_act_idx;
      use_target = 1'b1;
    end else if (sc_flags.up_found) begin
      day_calc   = (sc_ended != '0) ? DAY_BREAK : DAY_WAITING;
      idx_calc   = sc_up_idx;
      target     = sc_up_start;
      use_target = 1'b1;
    end
    if (!have_list_r) begin
      day_calc   = DAY_NOLIST;
      idx_calc   = '0;
      use_target = 1'b0;
    end
  end

  // countdown: clamp at zero, saturate at the 31-bit top
  assign diff = {target[31], target} - {now_r[31], now_r};
  always_comb begin
    if (!use_target || diff[32]) begin
      cd_calc = '0;
    end else if (diff[31]) begin
      cd_calc = CD_MAX;
    end else begin
      cd_calc = diff[30:0];
    end
  end

  // pulse on a grown ended count or a newly active interval
  assign pulse_calc = prev_valid_r &&
                      ((sc_ended > prev_ended_r) ||
                       (sc_flags.act_found &&
                        (!prev_act_valid_r || (sc_act_idx != prev_act_idx_r))));

  assign load_tick = (state_r == ST_SCAN) && scan_done && tick_r;
  assign emit      = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt          = state_r;
    live_cnt_nxt       = live_cnt_r;
    pend_cnt_nxt       = pend_cnt_r;
    loading_nxt        = loading_r;
    have_list_nxt      = have_list_r;
    tick_nxt           = tick_r;
    prev_valid_nxt     = prev_valid_r;
    prev_ended_nxt     = prev_ended_r;
    prev_act_valid_nxt = prev_act_valid_r;
    prev_act_idx_nxt   = prev_act_idx_r;
    div_start          = 1'b0;
    out_valid_nxt      = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_SET_COUNT: begin
              if (cnt_clamped == '0) begin
                // empty list commits at once; resync quietly
                live_cnt_nxt       = '0;
                pend_cnt_nxt       = '0;
                have_list_nxt      = 1'b1;
                loading_nxt        = 1'b0;
                prev_valid_nxt     = 1'b1;
                prev_ended_nxt     = '0;
                prev_act_valid_nxt = 1'b0;
              end else begin
                pend_cnt_nxt = cnt_clamped;
                loading_nxt  = 1'b1;
              end
            end
            KIND_WRITE_ENTRY: begin
              if (wr_en && entry_last) begin
                live_cnt_nxt  = pend_cnt_r;
                pend_cnt_nxt  = '0;
                loading_nxt   = 1'b0;
                have_list_nxt = 1'b1;
                tick_nxt      = 1'b0;
                state_nxt     = ST_SCAN;
              end
            end
            KIND_TICK: begin
              tick_nxt  = 1'b1;
              state_nxt = ST_SCAN;
            end
            KIND_FORGET: begin
              // drop the committed list; a load in progress goes on
              live_cnt_nxt  = '0;
              have_list_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          prev_valid_nxt     = 1'b1;
          prev_ended_nxt     = sc_ended;
          prev_act_valid_nxt = sc_flags.act_found;
          prev_act_idx_nxt   = sc_act_idx;
          if (tick_r) begin
            div_start = 1'b1;
            state_nxt = ST_SPLIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SPLIT: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      live_cnt_r       <= '0;
      pend_cnt_r       <= '0;
      loading_r        <= 1'b0;
      have_list_r      <= 1'b0;
      tick_r           <= 1'b0;
      prev_valid_r     <= 1'b0;
      prev_ended_r     <= '0;
      prev_act_valid_r <= 1'b0;
      prev_act_idx_r   <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      live_cnt_r       <= live_cnt_nxt;
      pend_cnt_r       <= pend_cnt_nxt;
      loading_r        <= loading_nxt;
      have_list_r      <= have_list_nxt;
      tick_r           <= tick_nxt;
      prev_valid_r     <= prev_valid_nxt;
      prev_ended_r     <= prev_ended_nxt;
      prev_act_valid_r <= prev_act_valid_nxt;
      prev_act_idx_r   <= prev_act_idx_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // hold the time of the request for the scan and the countdown
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= in_ch.now_time;
    end
  end

  // capture the tick result as the scan finishes
  always_ff @(posedge clk) begin
    if (load_tick) begin
      day_r    <= day_calc;
      idx_r    <= idx_calc;
      ended_r  <= sc_ended;
      cd_r     <= cd_calc;
      hasn_r   <= have_list_r && sc_flags.act_found && sc_flags.nxt_found;
      nstart_r <= (have_list_r && sc_flags.act_found && sc_flags.nxt_found) ?
                  sc_nxt_start : 32'sd0;
      pulse_r  <= pulse_calc;
    end
    if ((state_r == ST_SPLIT) && div_done) begin
      hours_r <= div_hours;
      mins_r  <= div_mins;
      secs_r  <= div_secs;
    end
  end

  ist_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(cd_calc),
    .busy    (div_busy),
    .done    (div_done),
    .hours   (div_hours),
    .mins    (div_mins),
    .secs    (div_secs)
  );

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      o_day_r    <= day_r;
      o_idx_r    <= 5'(idx_r);
      o_ended_r  <= 6'(ended_r);
      o_cd_r     <= cd_r;
      o_hours_r  <= hours_r;
      o_mins_r   <= mins_r;
      o_secs_r   <= secs_r;
      o_hasn_r   <= hasn_r;
      o_nstart_r <= nstart_r;
      o_pulse_r  <= pulse_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.day_kind      = o_day_r;
  assign out_ch.item_index    = o_idx_r;
  assign out_ch.ended_count   = o_ended_r;
  assign out_ch.countdown     = o_cd_r;
  assign out_ch.count_hours   = o_hours_r;
  assign out_ch.count_minutes = o_mins_r;
  assign out_ch.count_seconds = o_secs_r;
  assign out_ch.has_next      = o_hasn_r;
  assign out_ch.next_start    = o_nstart_r;
  assign out_ch.pulse         = o_pulse_r;

  `IST_ASSERT(a_div_only_in_split, div_busy |-> (state_r == ST_SPLIT), "split outside its step")
  `IST_ASSERT(a_scan_done_in_scan, scan_done |-> (state_r == ST_SCAN), "scan finished outside the scan step")
  `IST_ASSERT(a_next_only_active, out_ch.valid && out_ch.has_next |-> out_ch.day_kind == DAY_ACTIVE, "next start reported without an active interval")
  `IST_ASSERT(a_hms_range, out_ch.valid |-> (out_ch.count_minutes < 6'd60) && (out_ch.count_seconds < 6'd60), "minutes or seconds out of range")
  `IST_ASSERT_NEXT(a_emit_sets_valid, emit, out_ch.valid && (state_r == ST_IDLE), "emitted result not presented")

endmodule
